// ----- hdl/i2cm_pkg.sv -----
package i2cm_pkg;

	// Width of the segment delay counter
	localparam int unsigned DELAY_WIDTH = 16;
	// Width of the segment length register
	localparam int unsigned SEG_WIDTH = 16;
	localparam logic [SEG_WIDTH-1:0] SEG_TICKS_RESET = SEG_WIDTH'(150);

	// Bits per byte on the wire
	localparam logic [3:0] BYTE_BITS = 4'd8;

	// Command codes carried by a request
	typedef enum logic [2:0] {
		CMD_NONE      = 3'd0,
		CMD_START     = 3'd1,
		CMD_STOP      = 3'd2,
		CMD_WRITE     = 3'd3,
		CMD_READ_ACK  = 3'd4,
		CMD_READ_NACK = 3'd5
	} cmd_t;

	// Sequencer phases, one per delay segment
	typedef enum logic [4:0] {
		PH_IDLE   = 5'd0,
		PH_ST_A   = 5'd1,
		PH_ST_B   = 5'd2,
		PH_ST_C   = 5'd3,
		PH_SP_A   = 5'd4,
		PH_SP_B   = 5'd5,
		PH_SP_C   = 5'd6,
		PH_SP_D   = 5'd7,
		PH_WR_LO  = 5'd8,
		PH_WR_DAT = 5'd9,
		PH_WR_HI  = 5'd10,
		PH_WA_A   = 5'd11,
		PH_WA_B   = 5'd12,
		PH_WA_C   = 5'd13,
		PH_RD_LO  = 5'd14,
		PH_RD_HI  = 5'd15,
		PH_AK_A   = 5'd16,
		PH_AK_B   = 5'd17,
		PH_AK_C   = 5'd18,
		PH_AK_D   = 5'd19
	} phase_t;

	// One tick of input
	typedef struct packed {
		logic [2:0] command;
		logic [7:0] tx_byte;
		logic       sda_in;
	} req_t;

	// One tick of output
	typedef struct packed {
		logic       scl_out;
		logic       sda_out;
		logic       busy_res;
		logic       done_res;
		logic       success;
		logic [7:0] rx_byte;
	} rsp_t;

endpackage

// ----- hdl/i2c_master_bit_sequencer_unit.sv -----
// I2C master bit sequencer, tick driven.
// Request channel (req_valid, req_stall, req): each accepted request is one
// bus tick carrying an optional command, the byte to send and the sampled
// SDA level. Commands that arrive while a sequence runs are ignored.
// Response channel (rsp_valid, rsp_stall, rsp): exactly one response per
// request, in order: SCL and SDA drive levels, busy, a one-tick done pulse,
// success and the last received byte.
// Configuration: cfg_we writes cfg_data as the number of ticks per delay
// segment (zero counts as one). Write it only while no request is in flight.
// Timing: one request per clock cycle while req_stall is low; the state update
// for a tick is one pass through the sequencer logic, and the response is
// registered on acceptance. An output register plus a skid
// register decouple the sides: requests are still taken while one response
// waits, and req_stall rises only once both are full.
// Reset: the sequencer goes idle with both lines released, the segment
// length returns to 150 ticks and both response registers empty.
module i2c_master_bit_sequencer_unit
	import i2cm_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [SEG_WIDTH-1:0] cfg_data,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp
);

	logic [SEG_WIDTH-1:0]   seg_ticks_q;
	phase_t                 phase_q, phase_d;
	logic [3:0]             bits_left_q, bits_left_d;
	logic [7:0]             shift_q, shift_d;
	logic [DELAY_WIDTH-1:0] wait_q, wait_d;
	logic                   scl_q, scl_d;
	logic                   sda_q, sda_d;
	logic                   ok_q, ok_d;
	logic                   read_ack_q, read_ack_d;
	logic [7:0]             rx_hold_q, rx_hold_d;
	logic                   done_d;

	logic [SEG_WIDTH+DELAY_WIDTH-1:0] seg_ext;
	logic [DELAY_WIDTH-1:0] limit;
	logic                   req_fire, rsp_fire;
	rsp_t                   rsp_d;
	rsp_t                   skid_q;
	logic                   skid_valid_q;
	logic                   rsp_valid_q;
	rsp_t                   rsp_q;

	// Segment length truncated or widened to the counter, zero as one
	assign seg_ext = {{DELAY_WIDTH{1'b0}}, seg_ticks_q};
	always_comb begin
		limit = seg_ext[DELAY_WIDTH-1:0];
		if (limit == '0) begin
			limit = DELAY_WIDTH'(1);
		end
	end

	assign req_stall = skid_valid_q;
	assign req_fire  = req_valid && !req_stall;
	assign rsp_fire  = rsp_valid_q && !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Hold the segment length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_ticks_q <= SEG_TICKS_RESET;
		end else if (cfg_we) begin
			seg_ticks_q <= cfg_data;
		end
	end

	// Advance the sequencer by one tick
	always_comb begin
		phase_d     = phase_q;
		bits_left_d = bits_left_q;
		shift_d     = shift_q;
		wait_d      = wait_q;
		scl_d       = scl_q;
		sda_d       = sda_q;
		ok_d        = ok_q;
		read_ack_d  = read_ack_q;
		rx_hold_d   = rx_hold_q;
		done_d      = 1'b0;

		// Launch a sequence from idle
		if (phase_q == PH_IDLE) begin
			unique case (req.command)
				CMD_START: begin
					sda_d   = 1'b1;
					scl_d   = 1'b1;
					phase_d = PH_ST_A;
				end
				CMD_STOP: begin
					scl_d   = 1'b0;
					phase_d = PH_SP_A;
				end
				CMD_WRITE: begin
					scl_d       = 1'b0;
					shift_d     = req.tx_byte;
					bits_left_d = BYTE_BITS;
					phase_d     = PH_WR_LO;
				end
				CMD_READ_ACK, CMD_READ_NACK: begin
					sda_d       = 1'b1;
					scl_d       = 1'b0;
					shift_d     = '0;
					bits_left_d = BYTE_BITS;
					read_ack_d  = (req.command == CMD_READ_ACK);
					phase_d     = PH_RD_LO;
				end
				default: begin
				end
			endcase
			wait_d = '0;
		end

		// Count the segment and act at its last tick
		if (phase_d != PH_IDLE) begin
			wait_d = wait_d + DELAY_WIDTH'(1);
			if (wait_d >= limit) begin
				wait_d = '0;
				unique case (phase_d)
					PH_ST_A: begin
						if (!req.sda_in) begin
							ok_d = 1'b0; done_d = 1'b1; phase_d = PH_IDLE;
						end else begin
							sda_d = 1'b0; phase_d = PH_ST_B;
						end
					end
					PH_ST_B: begin
						if (req.sda_in) begin
							ok_d = 1'b0; done_d = 1'b1; phase_d = PH_IDLE;
						end else begin
							sda_d = 1'b0; phase_d = PH_ST_C;
						end
					end
					PH_ST_C: begin
						ok_d = 1'b1; done_d = 1'b1; phase_d = PH_IDLE;
					end
					PH_SP_A: begin
						sda_d = 1'b0; phase_d = PH_SP_B;
					end
					PH_SP_B: begin
						scl_d = 1'b1; phase_d = PH_SP_C;
					end
					PH_SP_C: begin
						sda_d = 1'b1; phase_d = PH_SP_D;
					end
					PH_SP_D: begin
						ok_d = 1'b1; done_d = 1'b1; phase_d = PH_IDLE;
					end
					PH_WR_LO: begin
						sda_d   = shift_d[7];
						shift_d = {shift_d[6:0], 1'b0};
						phase_d = PH_WR_DAT;
					end
					PH_WR_DAT: begin
						scl_d = 1'b1; phase_d = PH_WR_HI;
					end
					PH_WR_HI: begin
						bits_left_d = bits_left_d - 4'd1;
						scl_d       = 1'b0;
						phase_d     = (bits_left_d != '0) ? PH_WR_LO : PH_WA_A;
					end
					PH_WA_A: begin
						sda_d = 1'b1; phase_d = PH_WA_B;
					end
					PH_WA_B: begin
						scl_d = 1'b1; phase_d = PH_WA_C;
					end
					PH_WA_C: begin
						scl_d = 1'b0; ok_d = !req.sda_in; done_d = 1'b1;
						phase_d = PH_IDLE;
					end
					PH_RD_LO: begin
						scl_d = 1'b1; phase_d = PH_RD_HI;
					end
					PH_RD_HI: begin
						shift_d     = {shift_d[6:0], req.sda_in};
						bits_left_d = bits_left_d - 4'd1;
						scl_d       = 1'b0;
						if (bits_left_d != '0) begin
							phase_d = PH_RD_LO;
						end else begin
							rx_hold_d = shift_d;
							phase_d   = PH_AK_A;
						end
					end
					PH_AK_A: begin
						sda_d = !read_ack_d; phase_d = PH_AK_B;
					end
					PH_AK_B: begin
						scl_d = 1'b1; phase_d = PH_AK_C;
					end
					PH_AK_C: begin
						scl_d = 1'b0; phase_d = PH_AK_D;
					end
					PH_AK_D: begin
						ok_d = 1'b1; done_d = 1'b1; phase_d = PH_IDLE;
					end
					default: begin
						phase_d = PH_IDLE;
					end
				endcase
			end
		end

		rsp_d.scl_out  = scl_d;
		rsp_d.sda_out  = sda_d;
		rsp_d.busy_res = (phase_d != PH_IDLE);
		rsp_d.done_res = done_d;
		rsp_d.success  = ok_d;
		rsp_d.rx_byte  = rx_hold_d;
	end

	// Commit sequencer state on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			bits_left_q <= '0;
			shift_q     <= '0;
			wait_q      <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			ok_q        <= 1'b0;
			read_ack_q  <= 1'b0;
			rx_hold_q   <= '0;
		end else if (req_fire) begin
			phase_q     <= phase_d;
			bits_left_q <= bits_left_d;
			shift_q     <= shift_d;
			wait_q      <= wait_d;
			scl_q       <= scl_d;
			sda_q       <= sda_d;
			ok_q        <= ok_d;
			read_ack_q  <= read_ack_d;
			rx_hold_q   <= rx_hold_d;
		end
	end

	// Output register and skid register flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (rsp_fire) begin
				skid_valid_q <= 1'b0;
			end
		end else if (req_fire) begin
			if (rsp_valid_q && !rsp_fire) begin
				skid_valid_q <= 1'b1;
			end else begin
				rsp_valid_q <= 1'b1;
			end
		end else if (rsp_fire) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Response payloads: drain the skid first, else take the new response
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (rsp_fire) begin
				rsp_q <= skid_q;
			end
		end else if (req_fire) begin
			if (rsp_valid_q && !rsp_fire) begin
				skid_q <= rsp_d;
			end else begin
				rsp_q <= rsp_d;
			end
		end
	end

	// A full skid register implies a waiting output register
	a_skid_implies_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> rsp_valid_q)
		else $error("skid register full while output register empty");

	// The delay counter is cleared whenever the sequencer is idle
	a_idle_counter: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (wait_q == '0))
		else $error("delay counter running while idle");

	// A byte never holds more than eight bits to move
	a_bits_bound: assert property (@(posedge clk) disable iff (!arst_n)
		bits_left_q <= BYTE_BITS)
		else $error("bit counter out of range");

	// A finished sequence leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && done_d) |=> (phase_q == PH_IDLE))
		else $error("sequencer busy after done");

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
	import i2cm_pkg::*;

	localparam int unsigned TIMEOUT_CYCLES = 500000;
	localparam int unsigned SETTLE_MAX = 600;
	localparam int unsigned LONG_HOLD = 40;
	localparam int unsigned NO_LIMIT = 32'hFFFF_FFFF;
	localparam int unsigned PHASES = 6;
	localparam int unsigned PLAN_ROWS = 21;

	// Command codes the block has no use for
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;

	// How the far end answers on SDA for each tick
	typedef enum logic [1:0] {
		LINE_FOLLOW,
		LINE_LOW,
		LINE_HIGH,
		LINE_RAND
	} line_t;

	typedef enum logic [1:0] {
		ROW_TICK,
		ROW_SEQ,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [2:0]           cmd;
		logic [7:0]           tx;
		line_t                line;
		logic                 noisy;
		logic                 typed;
		rsp_t                 exp;
		logic [SEG_WIDTH-1:0] seg;
	} plan_row_t;

	localparam rsp_t RSP_RESET_IDLE = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
		done_res: 1'b0, success: 1'b0, rx_byte: 8'h00};
	localparam rsp_t RSP_BUS_TAKEN = '{scl_out: 1'b1, sda_out: 1'b1, busy_res: 1'b0,
		done_res: 1'b1, success: 1'b0, rx_byte: 8'h00};
	localparam rsp_t NO_RSP = '0;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [SEG_WIDTH-1:0] cfg_data = '0;
	logic                 req_valid = 1'b0;
	logic                 req_stall;
	req_t                 req = '0;
	logic                 rsp_valid;
	logic                 rsp_stall = 1'b0;
	rsp_t                 rsp;

	// Bus sequencer state as predicted
	logic [SEG_WIDTH-1:0]   seg_ticks;
	phase_t                 bus_phase;
	logic [3:0]             bits_left;
	logic [7:0]             shifter;
	logic [DELAY_WIDTH-1:0] seg_count;
	logic                   scl_lv;
	logic                   sda_lv;
	logic                   ok_lv;
	logic                   ack_read;
	logic                   done_lv;
	logic [7:0]             rx_last;

	rsp_t        line_state_q[$];
	int unsigned errors = 0;
	int unsigned ticks_sent = 0;
	int unsigned seg_writes = 0;
	int unsigned seq_done = 0;
	int unsigned seq_ok = 0;
	int unsigned hold_cycles = 0;
	int unsigned cycle_count = 0;
	bit          calm = 1'b0;

	i2c_master_bit_sequencer_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always #5 clk = ~clk;

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > TIMEOUT_CYCLES) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void enter(phase_t p);
		bus_phase = p;
		seg_count = '0;
	endfunction

	function automatic void conclude(logic ok);
		ok_lv     = ok;
		bus_phase = PH_IDLE;
		seg_count = '0;
		done_lv   = 1'b1;
	endfunction

	// Advance the bus sequencer by one tick and return the line state it shows
	function automatic rsp_t advance_bus(req_t r);
		logic [DELAY_WIDTH-1:0] lim;
		rsp_t                   o;
		lim = DELAY_WIDTH'(seg_ticks);
		if (lim == '0) begin
			lim = DELAY_WIDTH'(1);
		end
		done_lv = 1'b0;

		// accept a command only while idle
		if (bus_phase == PH_IDLE) begin
			case (r.command)
				CMD_START: begin
					sda_lv = 1'b1;
					scl_lv = 1'b1;
					enter(PH_ST_A);
				end
				CMD_STOP: begin
					scl_lv = 1'b0;
					enter(PH_SP_A);
				end
				CMD_WRITE: begin
					scl_lv    = 1'b0;
					shifter   = r.tx_byte;
					bits_left = BYTE_BITS;
					enter(PH_WR_LO);
				end
				CMD_READ_ACK, CMD_READ_NACK: begin
					sda_lv    = 1'b1;
					scl_lv    = 1'b0;
					shifter   = '0;
					bits_left = BYTE_BITS;
					ack_read  = (r.command == CMD_READ_ACK);
					enter(PH_RD_LO);
				end
				default: ;
			endcase
		end

		// count out the segment, act on its last tick
		if (bus_phase != PH_IDLE) begin
			seg_count = seg_count + 1'b1;
			if (seg_count >= lim) begin
				case (bus_phase)
					PH_ST_A: begin
						if (!r.sda_in) begin
							conclude(1'b0);
						end else begin
							sda_lv = 1'b0;
							enter(PH_ST_B);
						end
					end
					PH_ST_B: begin
						if (r.sda_in) begin
							conclude(1'b0);
						end else begin
							sda_lv = 1'b0;
							enter(PH_ST_C);
						end
					end
					PH_ST_C: conclude(1'b1);
					PH_SP_A: begin
						sda_lv = 1'b0;
						enter(PH_SP_B);
					end
					PH_SP_B: begin
						scl_lv = 1'b1;
						enter(PH_SP_C);
					end
					PH_SP_C: begin
						sda_lv = 1'b1;
						enter(PH_SP_D);
					end
					PH_SP_D: conclude(1'b1);
					PH_WR_LO: begin
						sda_lv  = shifter[7];
						shifter = {shifter[6:0], 1'b0};
						enter(PH_WR_DAT);
					end
					PH_WR_DAT: begin
						scl_lv = 1'b1;
						enter(PH_WR_HI);
					end
					PH_WR_HI: begin
						bits_left = bits_left - 1'b1;
						scl_lv    = 1'b0;
						enter(bits_left != 0 ? PH_WR_LO : PH_WA_A);
					end
					PH_WA_A: begin
						sda_lv = 1'b1;
						enter(PH_WA_B);
					end
					PH_WA_B: begin
						scl_lv = 1'b1;
						enter(PH_WA_C);
					end
					PH_WA_C: begin
						scl_lv = 1'b0;
						conclude(!r.sda_in);
					end
					PH_RD_LO: begin
						scl_lv = 1'b1;
						enter(PH_RD_HI);
					end
					PH_RD_HI: begin
						shifter   = {shifter[6:0], r.sda_in};
						bits_left = bits_left - 1'b1;
						scl_lv    = 1'b0;
						if (bits_left != 0) begin
							enter(PH_RD_LO);
						end else begin
							rx_last = shifter;
							enter(PH_AK_A);
						end
					end
					PH_AK_A: begin
						sda_lv = ~ack_read;
						enter(PH_AK_B);
					end
					PH_AK_B: begin
						scl_lv = 1'b1;
						enter(PH_AK_C);
					end
					PH_AK_C: begin
						scl_lv = 1'b0;
						enter(PH_AK_D);
					end
					PH_AK_D: conclude(1'b1);
					default: enter(PH_IDLE);
				endcase
			end
		end

		o.scl_out  = scl_lv;
		o.sda_out  = sda_lv;
		o.busy_res = (bus_phase != PH_IDLE);
		o.done_res = done_lv;
		o.success  = ok_lv;
		o.rx_byte  = rx_last;
		return o;
	endfunction

	function automatic int unsigned draw_wait();
		return calm ? 0 : $urandom_range(0, 4);
	endfunction

	// SDA as seen on the bus: the far end follows it, holds it low or high, or pulls it low at random
	function automatic logic line_level(line_t mode);
		case (mode)
			LINE_LOW:  return 1'b0;
			LINE_HIGH: return 1'b1;
			LINE_RAND: return sda_lv & 1'($urandom_range(0, 1));
			default:   return sda_lv;
		endcase
	endfunction

	// Offer one request, hold it until taken, then record what it should show
	task automatic send_tick(req_t r, logic typed, rsp_t fixed);
		int unsigned wait_n;
		rsp_t        predicted;
		wait_n = draw_wait();
		if (wait_n != 0) begin
			req_valid <= 1'b0;
			repeat (wait_n) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		predicted = advance_bus(r);
		line_state_q.push_back(typed ? fixed : predicted);
		ticks_sent++;
	endtask

	// Issue a command, then tick until the sequence ends or the budget runs out
	task automatic run_sequence(logic [2:0] cmd, logic [7:0] tx, line_t mode, bit noisy,
			int unsigned stop_at);
		req_t r;
		r.command = cmd;
		r.tx_byte = tx;
		r.sda_in  = line_level(mode);
		send_tick(r, 1'b0, NO_RSP);
		while (bus_phase != PH_IDLE && ticks_sent < stop_at) begin
			r.command = (noisy && $urandom_range(0, 2) == 0) ? 3'($urandom_range(1, 7))
				: CMD_NONE;
			r.tx_byte = 8'($urandom);
			r.sda_in  = line_level(mode);
			send_tick(r, 1'b0, NO_RSP);
		end
	endtask

	// Let the sequence wind down, drain all responses, then write the segment length
	task automatic set_segment(logic [SEG_WIDTH-1:0] value);
		run_sequence(CMD_NONE, 8'h00, LINE_RAND, 1'b0, ticks_sent + SETTLE_MAX);
		req_valid <= 1'b0;
		do @(posedge clk); while (line_state_q.size() != 0);
		repeat (2) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		seg_ticks = value;
		seg_writes++;
	endtask

	task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
		end
	endtask

	// Response side: stall at random, compare each response with the oldest prediction
	initial begin : response_side
		int unsigned wait_n;
		rsp_t        want;
		@(posedge arst_n);
		forever begin
			wait_n      = (hold_cycles != 0) ? hold_cycles : draw_wait();
			hold_cycles = 0;
			if (wait_n != 0) begin
				rsp_stall <= 1'b1;
				repeat (wait_n) @(posedge clk);
			end
			rsp_stall <= 1'b0;
			do @(posedge clk); while (!rsp_valid);
			if (line_state_q.size() == 0) begin
				errors++;
				$display("%0t: response %h with nothing expected", $time, rsp);
			end else begin
				want = line_state_q.pop_front();
				check_field("scl_out", 8'(want.scl_out), 8'(rsp.scl_out));
				check_field("sda_out", 8'(want.sda_out), 8'(rsp.sda_out));
				check_field("busy_res", 8'(want.busy_res), 8'(rsp.busy_res));
				check_field("done_res", 8'(want.done_res), 8'(rsp.done_res));
				check_field("success", 8'(want.success), 8'(rsp.success));
				check_field("rx_byte", want.rx_byte, rsp.rx_byte);
			end
			if (rsp.done_res === 1'b1) begin
				seq_done++;
				if (rsp.success === 1'b1) begin
					seq_ok++;
				end
			end
		end
	end

	// Request side: directed plan, then random transfers over several segment lengths
	initial begin : request_side
		plan_row_t            plan [PLAN_ROWS];
		logic [SEG_WIDTH-1:0] seg_plan [PHASES];
		int unsigned          tick_plan [PHASES];
		int unsigned          stop_at;
		int unsigned          pick;
		int unsigned          n_bytes;
		bit                   noisy;
		req_t                 r;

		seg_ticks = SEG_TICKS_RESET;
		bus_phase = PH_IDLE;
		bits_left = '0;
		shifter   = '0;
		seg_count = '0;
		scl_lv    = 1'b1;
		sda_lv    = 1'b1;
		ok_lv     = 1'b0;
		ack_read  = 1'b0;
		done_lv   = 1'b0;
		rx_last   = '0;

		plan = '{
			'{ROW_TICK, CMD_NONE, 8'h00, LINE_HIGH, 1'b0, 1'b1, RSP_RESET_IDLE, 16'd0},
			'{ROW_TICK, CMD_SPARE_6, 8'hFF, LINE_LOW, 1'b0, 1'b1, RSP_RESET_IDLE, 16'd0},
			'{ROW_TICK, CMD_SPARE_7, 8'h00, LINE_HIGH, 1'b0, 1'b1, RSP_RESET_IDLE, 16'd0},
			'{ROW_CFG, CMD_NONE, 8'h00, LINE_FOLLOW, 1'b0, 1'b0, NO_RSP, 16'd0},
			'{ROW_TICK, CMD_START, 8'h00, LINE_LOW, 1'b0, 1'b1, RSP_BUS_TAKEN, 16'd0},
			'{ROW_SEQ, CMD_START, 8'h00, LINE_FOLLOW, 1'b0, 1'b0, NO_RSP, 16'd0},
			'{ROW_SEQ, CMD_WRITE, 8'h00, LINE_LOW, 1'b0, 1'b0, NO_RSP, 16'd0},
			'{ROW_SEQ, CMD_WRITE, 8'hFF, LINE_FOLLOW, 1'b0, 1'b0, NO_RSP, 16'd0},
			'{ROW_SEQ, CMD_WRITE, 8'hA5, LINE_LOW, 1'b1, 1'b0, NO_RSP, 16'd0},
			'{ROW_SEQ, CMD_READ_ACK, 8'h00, LINE_FOLLOW, 1'b0, 1'b0, NO_RSP, 16'd0},
			'{ROW_SEQ, CMD_READ_NACK, 8'hFF, LINE_LOW, 1'b1, 1'b0, NO_RSP, 16'd0},
			'{ROW_SEQ, CMD_STOP, 8'h00, LINE_FOLLOW, 1'b0, 1'b0, NO_RSP, 16'd0},
			'{ROW_SEQ, CMD_START, 8'h00, LINE_HIGH, 1'b0, 1'b0, NO_RSP, 16'd0},
			'{ROW_CFG, CMD_NONE, 8'h00, LINE_FOLLOW, 1'b0, 1'b0, NO_RSP, 16'd1},
			'{ROW_SEQ, CMD_STOP, 8'h00, LINE_FOLLOW, 1'b0, 1'b0, NO_RSP, 16'd0},
			'{ROW_SEQ, CMD_START, 8'h00, LINE_FOLLOW, 1'b0, 1'b0, NO_RSP, 16'd0},
			'{ROW_SEQ, CMD_WRITE, 8'h5A, LINE_LOW, 1'b0, 1'b0, NO_RSP, 16'd0},
			'{ROW_SEQ, CMD_STOP, 8'h00, LINE_HIGH, 1'b0, 1'b0, NO_RSP, 16'd0},
			'{ROW_CFG, CMD_NONE, 8'h00, LINE_FOLLOW, 1'b0, 1'b0, NO_RSP, 16'd3},
			'{ROW_SEQ, CMD_READ_ACK, 8'h3C, LINE_FOLLOW, 1'b0, 1'b0, NO_RSP, 16'd0},
			'{ROW_SEQ, CMD_STOP, 8'h00, LINE_FOLLOW, 1'b0, 1'b0, NO_RSP, 16'd0}
		};
		seg_plan  = '{16'd0, 16'd1, 16'd2, 16'd5, 16'hFFFF, 16'd1};
		tick_plan = '{100, 200, 170, 110, 50, 60};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed plan
		foreach (plan[k]) begin
			case (plan[k].kind)
				ROW_CFG: set_segment(plan[k].seg);
				ROW_TICK: begin
					r.command = plan[k].cmd;
					r.tx_byte = plan[k].tx;
					r.sda_in  = line_level(plan[k].line);
					send_tick(r, plan[k].typed, plan[k].exp);
				end
				default: run_sequence(plan[k].cmd, plan[k].tx, plan[k].line, plan[k].noisy,
					NO_LIMIT);
			endcase
		end

		// random transfers, mostly start / bytes / stop with random bus answers
		for (int p = 0; p < PHASES; p++) begin
			set_segment(seg_plan[p]);
			calm    = (p == 1);
			stop_at = ticks_sent + tick_plan[p];
			if (p == 2) begin
				hold_cycles = LONG_HOLD;
			end
			while (ticks_sent < stop_at) begin
				pick  = $urandom_range(0, 99);
				noisy = ($urandom_range(0, 4) == 0);
				if (pick < 85) begin
					run_sequence(CMD_START, 8'($urandom), LINE_RAND, noisy, stop_at);
					n_bytes = $urandom_range(1, 3);
					repeat (n_bytes) begin
						run_sequence(3'($urandom_range(CMD_WRITE, CMD_READ_NACK)), 8'($urandom),
							LINE_RAND, noisy, stop_at);
					end
					run_sequence(CMD_STOP, 8'($urandom), LINE_RAND, noisy, stop_at);
				end else begin
					run_sequence(3'($urandom_range(0, 7)), 8'($urandom), LINE_RAND, 1'b1,
						stop_at);
				end
			end
		end
		calm = 1'b0;

		// drop valid, wait for the last responses, then allow a few spare cycles
		req_valid <= 1'b0;
		do @(posedge clk); while (line_state_q.size() != 0);
		repeat (8) @(posedge clk);

		$display("Ran %0d bus ticks under %0d segment lengths", ticks_sent, seg_writes);
		$display("%0d sequences completed, %0d reported success", seq_done, seq_ok);
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
